FILE: src/ssme_pkg.sv
// ----------------------------------------------------------------------------
// ssme_pkg
// shared types, sizes and codes of the sorted set merge engine
// ----------------------------------------------------------------------------
package ssme_pkg;

  localparam int LIST_DEPTH = 16;
  localparam int ADDR_W     = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
  localparam int DATA_W     = 32;

  // request op codes
  localparam logic [1:0] OP_LOAD_A = 2'd0;
  localparam logic [1:0] OP_LOAD_B = 2'd1;
  localparam logic [1:0] OP_START  = 2'd2;

  // set operation register codes
  localparam logic [1:0] SET_MERGE = 2'd0;
  localparam logic [1:0] SET_UNION = 2'd1;
  localparam logic [1:0] SET_INTER = 2'd2;
  localparam logic [1:0] SET_DIFF  = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_COMP
  } state_t;

  // decision of one walk step
  typedef struct packed {
    logic emit;
    logic take_b;
    logic inc_i;
    logic inc_j;
    logic done;
  } step_t;

endpackage

FILE: src/ssme_ram.sv
// ----------------------------------------------------------------------------
// ssme_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module ssme_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/ssme_step.sv
// ----------------------------------------------------------------------------
// ssme_step
// shared compare unit: decides one step of the two-pointer walk
// ----------------------------------------------------------------------------
module ssme_step import ssme_pkg::*; (
  input  logic [1:0]        set_op,
  input  logic [DATA_W-1:0] a,
  input  logic [DATA_W-1:0] b,
  input  logic              i_ok,
  input  logic              j_ok,
  output step_t             step
);

  logic lt_ab;
  logic lt_ba;

  assign lt_ab = $signed(a) < $signed(b);
  assign lt_ba = $signed(b) < $signed(a);

  always_comb begin
    step = '0;
    if (i_ok && j_ok) begin
      unique case (set_op)
        SET_MERGE: begin
          step.emit = 1'b1;
          if (lt_ab) begin
            step.inc_i = 1'b1;
          end else begin
            step.take_b = 1'b1;
            step.inc_j  = 1'b1;
          end
        end
        SET_UNION: begin
          step.emit = 1'b1;
          if (lt_ab) begin
            step.inc_i = 1'b1;
          end else if (lt_ba) begin
            step.take_b = 1'b1;
            step.inc_j  = 1'b1;
          end else begin
            step.inc_i = 1'b1;
            step.inc_j = 1'b1;
          end
        end
        SET_INTER: begin
          if (lt_ab) begin
            step.inc_i = 1'b1;
          end else if (lt_ba) begin
            step.inc_j = 1'b1;
          end else begin
            step.emit  = 1'b1;
            step.inc_i = 1'b1;
            step.inc_j = 1'b1;
          end
        end
        SET_DIFF: begin
          if (lt_ab) begin
            step.emit  = 1'b1;
            step.inc_i = 1'b1;
          end else if (lt_ba) begin
            step.inc_j = 1'b1;
          end else begin
            step.inc_i = 1'b1;
            step.inc_j = 1'b1;
          end
        end
        default: step.done = 1'b1;
      endcase
    end else if (i_ok && (set_op != SET_INTER)) begin
      // first list tail
      step.emit  = 1'b1;
      step.inc_i = 1'b1;
    end else if (j_ok && ((set_op == SET_MERGE) || (set_op == SET_UNION))) begin
      // second list tail
      step.emit   = 1'b1;
      step.take_b = 1'b1;
      step.inc_j  = 1'b1;
    end else begin
      step.done = 1'b1;
    end
  end

endmodule

FILE: src/ssme_ctrl.sv
// ----------------------------------------------------------------------------
// ssme_ctrl
// sequencer: loads, walk pointers, one-deep hold buffer and result register
// ----------------------------------------------------------------------------
module ssme_ctrl import ssme_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        op,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_data,
  output logic              we_a,
  output logic              we_b,
  output logic [ADDR_W-1:0] waddr_a,
  output logic [ADDR_W-1:0] waddr_b,
  output logic [ADDR_W-1:0] raddr_a,
  output logic [ADDR_W-1:0] raddr_b,
  input  logic [DATA_W-1:0] rdata_a,
  input  logic [DATA_W-1:0] rdata_b,
  output logic [1:0]        set_op,
  output logic              i_ok,
  output logic              j_ok,
  input  step_t             step,
  output logic              res_valid,
  output logic [DATA_W-1:0] value_res,
  output logic              last,
  output logic              empty_res
);

  localparam logic [CNT_W-1:0] FULL = CNT_W'(LIST_DEPTH);

  state_t            state, state_next;
  logic [CNT_W-1:0]  count_a, count_a_next;
  logic [CNT_W-1:0]  count_b, count_b_next;
  logic [CNT_W-1:0]  ptr_i, ptr_i_next;
  logic [CNT_W-1:0]  ptr_j, ptr_j_next;
  logic              pend_valid, pend_valid_next;
  logic [DATA_W-1:0] pend_value, pend_value_next;
  logic              res_valid_next;
  logic [DATA_W-1:0] value_res_next;
  logic              last_next;
  logic              empty_res_next;
  logic              accept;

  assign busy    = (state != ST_IDLE);
  assign accept  = start && !busy;
  assign i_ok    = ptr_i < count_a;
  assign j_ok    = ptr_j < count_b;
  assign waddr_a = count_a[ADDR_W-1:0];
  assign waddr_b = count_b[ADDR_W-1:0];
  assign raddr_a = ptr_i[ADDR_W-1:0];
  assign raddr_b = ptr_j[ADDR_W-1:0];
  assign we_a    = accept && (op == OP_LOAD_A) && (count_a < FULL);
  assign we_b    = accept && (op == OP_LOAD_B) && (count_b < FULL);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      count_a    <= '0;
      count_b    <= '0;
      ptr_i      <= '0;
      ptr_j      <= '0;
      pend_valid <= 1'b0;
      res_valid  <= 1'b0;
      set_op     <= SET_MERGE;
    end else begin
      state      <= state_next;
      count_a    <= count_a_next;
      count_b    <= count_b_next;
      ptr_i      <= ptr_i_next;
      ptr_j      <= ptr_j_next;
      pend_valid <= pend_valid_next;
      res_valid  <= res_valid_next;
      if (cfg_we) begin
        set_op <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_value <= pend_value_next;
    value_res  <= value_res_next;
    last       <= last_next;
    empty_res  <= empty_res_next;
  end

  always_comb begin
    state_next      = state;
    count_a_next    = count_a;
    count_b_next    = count_b;
    ptr_i_next      = ptr_i;
    ptr_j_next      = ptr_j;
    pend_valid_next = pend_valid;
    pend_value_next = pend_value;
    res_valid_next  = 1'b0;
    value_res_next  = value_res;
    last_next       = last;
    empty_res_next  = empty_res;
    unique case (state)
      ST_IDLE: begin
        if (we_a) begin
          count_a_next = count_a + 1'b1;
        end
        if (we_b) begin
          count_b_next = count_b + 1'b1;
        end
        if (accept && (op == OP_START)) begin
          ptr_i_next      = '0;
          ptr_j_next      = '0;
          pend_valid_next = 1'b0;
          state_next      = ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_COMP;
      end
      ST_COMP: begin
        if (step.done) begin
          res_valid_next  = 1'b1;
          last_next       = 1'b1;
          empty_res_next  = !pend_valid;
          value_res_next  = pend_valid ? pend_value : '0;
          pend_valid_next = 1'b0;
          count_a_next    = '0;
          count_b_next    = '0;
          state_next      = ST_IDLE;
        end else begin
          if (step.emit) begin
            // release the held item, keep the new one until the next is known
            if (pend_valid) begin
              res_valid_next = 1'b1;
              last_next      = 1'b0;
              empty_res_next = 1'b0;
              value_res_next = pend_value;
            end
            pend_valid_next = 1'b1;
            pend_value_next = step.take_b ? rdata_b : rdata_a;
          end
          if (step.inc_i) begin
            ptr_i_next = ptr_i + 1'b1;
          end
          if (step.inc_j) begin
            ptr_j_next = ptr_j + 1'b1;
          end
          state_next = ST_READ;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

FILE: src/sorted_set_merge_engine.sv
// ----------------------------------------------------------------------------
// sorted_set_merge_engine
// merge, union, intersection or difference of two loaded sorted lists
// ----------------------------------------------------------------------------
// a load is written while idle and leaves the block idle; a start runs at most
//   count_a + count_b walk steps and a final done step, each step a read state
//   then a compare state, set by the registered read of the list rams feeding
//   the shared compare unit; one result at most per step; requests while busy are ignored
// reset: synchronous; both lists empty, set operation merge, block idle
// the receiver cannot stall: each result strobes res_valid for one cycle
module sorted_set_merge_engine import ssme_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        op,
  input  logic [31:0]       value,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_data,
  output logic              res_valid,
  output logic [31:0]       value_res,
  output logic              last,
  output logic              empty_res
);

  // list ram ports
  logic              we_a;
  logic              we_b;
  logic [ADDR_W-1:0] waddr_a;
  logic [ADDR_W-1:0] waddr_b;
  logic [ADDR_W-1:0] raddr_a;
  logic [ADDR_W-1:0] raddr_b;
  logic [DATA_W-1:0] rdata_a;
  logic [DATA_W-1:0] rdata_b;

  // walk control between sequencer and compare unit
  logic [1:0]        set_op;
  logic              i_ok;
  logic              j_ok;
  step_t             step;

  // first list, appended at its fill count, read at pointer i
  ssme_ram #(
    .WIDTH (DATA_W),
    .DEPTH (LIST_DEPTH)
  ) u_ram_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr_a),
    .wdata (value),
    .raddr (raddr_a),
    .rdata (rdata_a)
  );

  // second list, appended at its fill count, read at pointer j
  ssme_ram #(
    .WIDTH (DATA_W),
    .DEPTH (LIST_DEPTH)
  ) u_ram_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (waddr_b),
    .wdata (value),
    .raddr (raddr_b),
    .rdata (rdata_b)
  );

  // signed compare and step decision, used once per walk step
  ssme_step u_step (
    .set_op (set_op),
    .a      (rdata_a),
    .b      (rdata_b),
    .i_ok   (i_ok),
    .j_ok   (j_ok),
    .step   (step)
  );

  // sequencer: read cycle, compare cycle, then back to read until done;
  // the hold buffer delays each result by one emit so that last is known
  ssme_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .op        (op),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .we_a      (we_a),
    .we_b      (we_b),
    .waddr_a   (waddr_a),
    .waddr_b   (waddr_b),
    .raddr_a   (raddr_a),
    .raddr_b   (raddr_b),
    .rdata_a   (rdata_a),
    .rdata_b   (rdata_b),
    .set_op    (set_op),
    .i_ok      (i_ok),
    .j_ok      (j_ok),
    .step      (step),
    .res_valid (res_valid),
    .value_res (value_res),
    .last      (last),
    .empty_res (empty_res)
  );

endmodule

FILE: src/ssme_checker.sv
// ----------------------------------------------------------------------------
// ssme_checker
// port level checks of the sorted set merge engine, bound to the top level
// ----------------------------------------------------------------------------
module ssme_checker import ssme_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic [1:0]  op,
  input logic        res_valid,
  input logic [31:0] value_res,
  input logic        last,
  input logic        empty_res
);

  // an empty result is a single final item with zero value
  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    (res_valid && empty_res) |-> (last && (value_res == '0)))
    else $error("empty result not a lone zero final item");

  // a start request makes the block busy
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (op == OP_START)) |=> busy)
    else $error("start request did not begin a run");

  // a run ends exactly with its final result
  a_end_with_last: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> (res_valid && last))
    else $error("run ended without a final result");

  // the final result is not directly followed by another result
  a_quiet_after_last: assert property (@(posedge clk) disable iff (rst)
    (res_valid && last) |=> !res_valid)
    else $error("result after final item");

endmodule

bind sorted_set_merge_engine ssme_checker u_ssme_checker (.*);

FILE: tb/ssme_checker.sv
// ----------------------------------------------------------------------------
// tb_ssme_checker
// watches the request, config and result ports of the merge engine, keeps
// its own copy of both lists and the set operation, predicts every run and
// compares each result field by field against the oldest prediction
// ----------------------------------------------------------------------------
module tb_ssme_checker import ssme_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  op,
  input  logic [31:0] value,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_data,
  input  logic        res_valid,
  input  logic [31:0] value_res,
  input  logic        last,
  input  logic        empty_res,
  output int          fail_count,
  output int          pending,
  output int          run_count,
  output int          result_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [DATA_W-1:0] val;
    logic              last;
    logic              empty;
  } result_t;

  logic signed [DATA_W-1:0] list_a [LIST_DEPTH];
  logic signed [DATA_W-1:0] list_b [LIST_DEPTH];
  int         count_a = 0;
  int         count_b = 0;
  logic [1:0] set_op = SET_MERGE;
  result_t    expected_q [$];
  int         fails = 0;
  int         runs = 0;
  int         results = 0;

  function automatic result_t element(logic [DATA_W-1:0] v);
    result_t r;
    r.val   = v;
    r.last  = 1'b0;
    r.empty = 1'b0;
    return r;
  endfunction

  // two-pointer walk over the loaded lists, then the tails
  task automatic predict_run();
    result_t                  run_q [$];
    result_t                  none;
    int                       i;
    int                       j;
    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] b;
    i = 0;
    j = 0;
    while (i < count_a && j < count_b) begin
      a = list_a[i];
      b = list_b[j];
      case (set_op)
        SET_MERGE: begin
          if (a < b) begin
            run_q.push_back(element(a));
            i++;
          end else begin
            run_q.push_back(element(b));
            j++;
          end
        end
        SET_UNION: begin
          if (a < b) begin
            run_q.push_back(element(a));
            i++;
          end else if (b < a) begin
            run_q.push_back(element(b));
            j++;
          end else begin
            run_q.push_back(element(a));
            i++;
            j++;
          end
        end
        SET_INTER: begin
          if (a < b) i++;
          else if (b < a) j++;
          else begin
            run_q.push_back(element(a));
            i++;
            j++;
          end
        end
        default: begin
          if (a < b) begin
            run_q.push_back(element(a));
            i++;
          end else if (b < a) begin
            j++;
          end else begin
            i++;
            j++;
          end
        end
      endcase
    end
    if (set_op != SET_INTER) begin
      for (; i < count_a; i++) run_q.push_back(element(list_a[i]));
    end
    if (set_op == SET_MERGE || set_op == SET_UNION) begin
      for (; j < count_b; j++) run_q.push_back(element(list_b[j]));
    end
    if (run_q.size() == 0) begin
      none.val   = '0;
      none.last  = 1'b1;
      none.empty = 1'b1;
      run_q.push_back(none);
    end else begin
      run_q[run_q.size()-1].last = 1'b1;
    end
    foreach (run_q[n]) expected_q.push_back(run_q[n]);
  endtask

  always @(posedge clk) begin
    result_t exp_r;
    if (rst) begin
      count_a = 0;
      count_b = 0;
      set_op  = SET_MERGE;
      expected_q.delete();
    end else begin
      if (res_valid) begin
        results++;
        if (expected_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected result value_res %0d last %0b empty_res %0b",
                   $time, $signed(value_res), last, empty_res);
        end else begin
          exp_r = expected_q.pop_front();
          if (value_res !== exp_r.val || last !== exp_r.last || empty_res !== exp_r.empty) begin
            fails++;
            $display("%0t: result mismatch expected %0d/%0b/%0b actual %0d/%0b/%0b",
                     $time, $signed(exp_r.val), exp_r.last, exp_r.empty,
                     $signed(value_res), last, empty_res);
          end
        end
      end
      if (cfg_we) set_op = cfg_data;
      if (start && !busy) begin
        case (op)
          OP_LOAD_A: begin
            if (count_a < LIST_DEPTH) begin
              list_a[count_a] = value;
              count_a++;
            end
          end
          OP_LOAD_B: begin
            if (count_b < LIST_DEPTH) begin
              list_b[count_b] = value;
              count_b++;
            end
          end
          OP_START: begin
            predict_run();
            count_a = 0;
            count_b = 0;
            runs++;
          end
          default: ;
        endcase
      end
    end
    fail_count   <= fails;
    pending      <= expected_q.size();
    run_count    <= runs;
    result_count <= results;
  end

endmodule

FILE: tb/tb_sorted_set_merge_engine.sv
// ----------------------------------------------------------------------------
// tb_sorted_set_merge_engine
// loads two lists and starts runs under every set operation: a short
// directed pass over extremes and corner cases, then random sorted lists
// with random gaps, overflowing loads, unsorted lists and ignored requests;
// the checker beside the block predicts and compares every result
// ----------------------------------------------------------------------------
module tb_sorted_set_merge_engine;
  timeunit 1ns;
  timeprecision 1ps;
  import ssme_pkg::*;

  // op code the block ignores
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int         NUM_REQUESTS = 500;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  op;
  logic [31:0] value;
  logic        cfg_we;
  logic [1:0]  cfg_data;
  logic        res_valid;
  logic [31:0] value_res;
  logic        last;
  logic        empty_res;

  int fail_count;
  int pending;
  int run_count;
  int result_count;

  int requests_sent = 0;
  int config_writes = 0;
  int seq_count = 0;
  bit burst = 1'b0;
  int a_vals [$];
  int b_vals [$];

  sorted_set_merge_engine dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .op        (op),
    .value     (value),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .res_valid (res_valid),
    .value_res (value_res),
    .last      (last),
    .empty_res (empty_res)
  );

  tb_ssme_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .op           (op),
    .value        (value),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .res_valid    (res_valid),
    .value_res    (value_res),
    .last         (last),
    .empty_res    (empty_res),
    .fail_count   (fail_count),
    .pending      (pending),
    .run_count    (run_count),
    .result_count (result_count)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // hard stop in case the block hangs
  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  // one request: optional random gap, then hold start until busy is low
  // at an edge; start is only touched here, in drain_results and at start-up
  task automatic send_request(input logic [1:0] req_op, input logic [31:0] req_val);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    op    <= req_op;
    value <= req_val;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    if (req_op != OP_UNUSED) requests_sent++;
  endtask

  // pause the sender until every predicted result has come out
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0 || busy);
  endtask

  // register write only while idle; a trailing load may still be finishing
  task automatic write_config(input logic [1:0] code);
    drain_results();
    repeat (3) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= code;
    @(posedge clk);
    cfg_we <= 1'b0;
    config_writes++;
  endtask

  // mode 0: full range, mode 1: narrow window so equal values are common,
  // otherwise: values at or next to the signed extremes and zero
  function automatic int draw_value(int mode, int base);
    case (mode)
      0: return $urandom;
      1: return base + $urandom_range(0, 8);
      default: begin
        case ($urandom_range(0, 6))
          0: return 32'h8000_0000;
          1: return 32'h8000_0001;
          2: return 32'hffff_ffff;
          3: return 0;
          4: return 1;
          5: return 32'h7fff_fffe;
          default: return 32'h7fff_ffff;
        endcase
      end
    endcase
  endfunction

  // content of one run; full runs push both lists to depth and past it
  task automatic make_lists(input bit full_run);
    int mode;
    int base;
    int n;
    mode = $urandom_range(0, 2);
    base = $urandom;
    a_vals.delete();
    b_vals.delete();
    for (int side = 0; side < 2; side++) begin
      if (full_run) n = $urandom_range(LIST_DEPTH, LIST_DEPTH + 2);
      else if ($urandom_range(0, 15) == 0) n = $urandom_range(LIST_DEPTH + 1, LIST_DEPTH + 4);
      else n = $urandom_range(0, 12);
      repeat (n) begin
        if (side == 0) a_vals.push_back(draw_value(mode, base));
        else b_vals.push_back(draw_value(mode, base));
      end
    end
    // most lists sorted, a few left as drawn
    if ($urandom_range(0, 9) != 0) begin
      a_vals.sort();
      b_vals.sort();
    end
  endtask

  initial begin
    rst      = 1'b1;
    start    = 1'b0;
    op       = OP_LOAD_A;
    value    = '0;
    cfg_we   = 1'b0;
    cfg_data = SET_MERGE;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: empty lists give the empty marker
    write_config(SET_MERGE);
    send_request(OP_START, 32'h0);
    // signed extremes on both sides, equal values in merge
    send_request(OP_LOAD_A, 32'h8000_0000);
    send_request(OP_LOAD_A, 32'h0000_0000);
    send_request(OP_LOAD_A, 32'h7fff_ffff);
    send_request(OP_LOAD_B, 32'h8000_0000);
    send_request(OP_LOAD_B, 32'hffff_ffff);
    send_request(OP_LOAD_B, 32'h7fff_ffff);
    send_request(OP_START, 32'hffff_ffff);
    // unused op code is ignored
    send_request(OP_UNUSED, $urandom);
    // union drops the duplicate and copies the tail
    write_config(SET_UNION);
    send_request(OP_LOAD_A, 32'd5);
    send_request(OP_LOAD_A, 32'd9);
    send_request(OP_LOAD_B, 32'd5);
    send_request(OP_START, 32'h0);
    // intersection with nothing in common
    write_config(SET_INTER);
    send_request(OP_LOAD_A, 32'd1);
    send_request(OP_LOAD_B, 32'd2);
    send_request(OP_START, 32'h0);
    // difference that removes everything, then an unsorted first list
    write_config(SET_DIFF);
    send_request(OP_LOAD_A, 32'd7);
    send_request(OP_LOAD_B, 32'd7);
    send_request(OP_START, 32'h0);
    send_request(OP_LOAD_A, 32'd3);
    send_request(OP_LOAD_A, 32'd1);
    send_request(OP_LOAD_B, 32'd1);
    send_request(OP_START, 32'h0);

    // random runs
    while (requests_sent < NUM_REQUESTS) begin
      seq_count++;
      // new set operation every few runs, after the block has gone quiet
      if (seq_count % 6 == 0) write_config(2'($urandom_range(0, 3)));
      burst = ($urandom_range(0, 3) == 0);
      make_lists($urandom_range(0, 5) == 0);
      // interleave the loads of both lists at random
      while (a_vals.size() + b_vals.size() > 0) begin
        if (b_vals.size() == 0 || (a_vals.size() > 0 && $urandom_range(0, 1) == 1))
          send_request(OP_LOAD_A, a_vals.pop_front());
        else
          send_request(OP_LOAD_B, b_vals.pop_front());
        if ($urandom_range(0, 29) == 0) send_request(OP_UNUSED, $urandom);
      end
      // now and then no start: the loads carry over into the next run
      if ($urandom_range(0, 19) != 0) send_request(OP_START, $urandom);
    end
    send_request(OP_START, $urandom);

    // wait out the last run plus the longest walk
    drain_results();
    repeat (80) @(posedge clk);

    $display("run covered %0d requests, %0d runs, %0d results, %0d register writes",
             requests_sent, run_count, result_count, config_writes);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/ssme_pkg.sv
src/ssme_ram.sv
src/ssme_step.sv
src/ssme_ctrl.sv
src/sorted_set_merge_engine.sv
src/ssme_checker.sv
tb/ssme_checker.sv
tb/tb_sorted_set_merge_engine.sv
